// ===== hdl/cse_pkg.sv =====
package cse_pkg;

    // Parse phases of the front end.
    typedef enum logic [1:0] {
        PH_STREAM_HDR,
        PH_CHUNK_HDR,
        PH_PAYLOAD,
        PH_HALT
    } phase_t;

    // End-of-file status codes.
    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_TOO_SHORT      = 3'd1,
        ST_BAD_TYPE       = 3'd2,
        ST_BAD_VERSION    = 3'd3,
        ST_BAD_HDR_SIZE   = 3'd4,
        ST_BAD_CHUNK_SIZE = 3'd5,
        ST_TRUNCATED      = 3'd6
    } status_t;

    // Result kinds as carried on the output tuser.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    // Stream header constants.
    localparam logic [31:0] SHDR_WORD      = 32'h5348_4452;
    localparam logic [31:0] HEADER_VERSION = 32'd2;

    // Result queue between front and back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;

    // Output tdata layout: payload byte, status code, total, zero fill.
    localparam int OUT_TDATA_W = 48;

    // One queue entry: the results caused by one input word.
    typedef struct packed {
        logic        has_payload;
        logic [7:0]  payload_byte;
        logic        has_status;
        status_t     status_code;
        logic [31:0] total_bytes;
    } result_entry_t;

endpackage

// ===== hdl/cse_front.sv =====
module cse_front #(
    parameter int FILE_HEADER_BYTES  = 244,
    parameter int CHUNK_HEADER_BYTES = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    input  logic                   in_accept,
    input  logic [7:0]             in_byte,
    input  logic                   in_final,
    output logic                   push,
    output cse_pkg::result_entry_t entry
);

    localparam logic [7:0]  FHB_LAST = 8'(FILE_HEADER_BYTES - 1);
    localparam logic [7:0]  CHB_LAST = 8'(CHUNK_HEADER_BYTES - 1);
    localparam logic [31:0] FHB_W32  = 32'(FILE_HEADER_BYTES);
    localparam logic [31:0] CHB_W32  = 32'(CHUNK_HEADER_BYTES);

    cse_pkg::phase_t  phase_reg, phase_next;
    cse_pkg::status_t err_reg, err_next;
    logic [7:0]       hbc_reg, hbc_next;
    logic [31:0]      type_reg, type_next;
    logic [31:0]      size_reg, size_next;
    logic [31:0]      remain_reg, remain_next;
    logic             match_reg, match_next;
    logic [31:0]      count_reg, count_next;
    logic [31:0]      wanted_reg;
    logic             too_short;
    logic             emit_payload;
    logic [31:0]      type_shifted, size_shifted, remain_shifted;

    assign type_shifted   = {type_reg[23:0], in_byte};
    assign size_shifted   = {size_reg[23:0], in_byte};
    assign remain_shifted = {remain_reg[23:0], in_byte};

    // Next state of the parser for the word on the input.
    always_comb begin
        phase_next   = phase_reg;
        err_next     = err_reg;
        hbc_next     = hbc_reg;
        type_next    = type_reg;
        size_next    = size_reg;
        remain_next  = remain_reg;
        match_next   = match_reg;
        count_next   = count_reg;
        too_short    = 1'b0;
        emit_payload = 1'b0;
        case (phase_reg)
            cse_pkg::PH_STREAM_HDR: begin
                too_short = 1'b1;
                if (hbc_reg < 8'd4) begin
                    type_next = type_shifted;
                end else if (hbc_reg < 8'd8) begin
                    size_next = size_shifted;
                end else if (hbc_reg >= 8'd20 && hbc_reg < 8'd24) begin
                    remain_next = remain_shifted;
                end
                if (hbc_reg >= FHB_LAST) begin
                    // Checks run on the completed words, this byte included.
                    if (type_next != cse_pkg::SHDR_WORD) begin
                        err_next = cse_pkg::ST_BAD_TYPE;
                    end else if (remain_next != cse_pkg::HEADER_VERSION) begin
                        err_next = cse_pkg::ST_BAD_VERSION;
                    end else if (size_next != FHB_W32) begin
                        err_next = cse_pkg::ST_BAD_HDR_SIZE;
                    end
                    phase_next  = (err_next != cse_pkg::ST_OK) ? cse_pkg::PH_HALT
                                                               : cse_pkg::PH_CHUNK_HDR;
                    hbc_next    = 8'd0;
                    type_next   = 32'd0;
                    size_next   = 32'd0;
                    remain_next = 32'd0;
                end else begin
                    hbc_next = hbc_reg + 8'd1;
                end
            end
            cse_pkg::PH_CHUNK_HDR: begin
                if (hbc_reg < 8'd4) begin
                    type_next = type_shifted;
                end else if (hbc_reg < 8'd8) begin
                    size_next = size_shifted;
                end
                if (hbc_reg >= CHB_LAST) begin
                    hbc_next = 8'd0;
                    if (size_next < CHB_W32) begin
                        err_next   = cse_pkg::ST_BAD_CHUNK_SIZE;
                        phase_next = cse_pkg::PH_HALT;
                    end else begin
                        remain_next = size_next - CHB_W32;
                        match_next  = (type_next == wanted_reg);
                        phase_next  = (remain_next != 32'd0) ? cse_pkg::PH_PAYLOAD
                                                             : cse_pkg::PH_CHUNK_HDR;
                    end
                    type_next = 32'd0;
                    size_next = 32'd0;
                end else begin
                    hbc_next = hbc_reg + 8'd1;
                end
            end
            cse_pkg::PH_PAYLOAD: begin
                if (match_reg) begin
                    emit_payload = 1'b1;
                    if (count_reg != 32'hFFFF_FFFF) begin
                        count_next = count_reg + 32'd1;
                    end
                end
                remain_next = remain_reg - 32'd1;
                if (remain_next == 32'd0) begin
                    phase_next = cse_pkg::PH_CHUNK_HDR;
                    hbc_next   = 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

    // Results caused by the input word, built from the updated state.
    always_comb begin
        entry              = '0;
        entry.has_payload  = emit_payload;
        entry.payload_byte = emit_payload ? in_byte : 8'd0;
        entry.has_status   = in_final;
        entry.status_code  = cse_pkg::ST_OK;
        entry.total_bytes  = 32'd0;
        if (in_final) begin
            if (too_short) begin
                entry.status_code = cse_pkg::ST_TOO_SHORT;
            end else if (err_next != cse_pkg::ST_OK) begin
                entry.status_code = err_next;
            end else if (phase_next != cse_pkg::PH_CHUNK_HDR || hbc_next != 8'd0) begin
                entry.status_code = cse_pkg::ST_TRUNCATED;
            end else if (count_next == 32'd0) begin
                entry.status_code = cse_pkg::ST_TRUNCATED;
            end else begin
                entry.total_bytes = count_next;
            end
        end
        push = in_accept && (emit_payload || in_final);
    end

    // Parser state; the final word of a file returns it to the reset value.
    always_ff @(posedge aclk) begin
        if (!aresetn || (in_accept && in_final)) begin
            phase_reg  <= cse_pkg::PH_STREAM_HDR;
            err_reg    <= cse_pkg::ST_OK;
            hbc_reg    <= 8'd0;
            type_reg   <= 32'd0;
            size_reg   <= 32'd0;
            remain_reg <= 32'd0;
            match_reg  <= 1'b0;
            count_reg  <= 32'd0;
        end else if (in_accept) begin
            phase_reg  <= phase_next;
            err_reg    <= err_next;
            hbc_reg    <= hbc_next;
            type_reg   <= type_next;
            size_reg   <= size_next;
            remain_reg <= remain_next;
            match_reg  <= match_next;
            count_reg  <= count_next;
        end
    end

    // Wanted chunk type register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wanted_reg <= 32'd0;
        end else if (cfg_we) begin
            wanted_reg <= cfg_wdata;
        end
    end

endmodule

// ===== hdl/cse_queue.sv =====
module cse_queue (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push,
    input  cse_pkg::result_entry_t push_entry,
    input  logic                   pop,
    output logic                   head_valid,
    output cse_pkg::result_entry_t head,
    output logic                   full
);

    cse_pkg::result_entry_t           slot_reg [cse_pkg::QUEUE_DEPTH];
    logic [cse_pkg::QUEUE_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [cse_pkg::QUEUE_PTR_W:0]    count_reg;
    logic                             do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == (cse_pkg::QUEUE_PTR_W + 1)'(cse_pkg::QUEUE_DEPTH));
    assign head       = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (!push && do_pop) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== hdl/cse_back.sv =====
module cse_back (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              head_valid,
    input  cse_pkg::result_entry_t            head,
    output logic                              pop,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [cse_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                              m_axis_tuser,
    output logic                              m_axis_tlast
);

    logic                            valid_reg, valid_next;
    logic                            half_reg, half_next;
    logic [cse_pkg::OUT_TDATA_W-1:0] data_reg, data_next;
    logic                            user_reg, user_next;
    logic                            last_reg, last_next;
    logic                            load;

    assign load = !valid_reg || m_axis_tready;

    // Split each entry into its words: payload first, then status.
    always_comb begin
        valid_next = valid_reg;
        half_next  = half_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = head_valid;
            if (head_valid) begin
                if (head.has_payload && !half_reg) begin
                    data_next = {{(cse_pkg::OUT_TDATA_W - 8){1'b0}}, head.payload_byte};
                    user_next = cse_pkg::KIND_PAYLOAD;
                    last_next = !head.has_status;
                    half_next = head.has_status;
                    pop       = !head.has_status;
                end else begin
                    data_next = {{(cse_pkg::OUT_TDATA_W - 43){1'b0}}, head.total_bytes,
                                 3'(head.status_code), 8'd0};
                    user_next = cse_pkg::KIND_STATUS;
                    last_next = 1'b1;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;
    assign m_axis_tlast  = last_reg;

    // A status word always closes the results of its input word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == cse_pkg::KIND_STATUS) |-> m_axis_tlast)
        else $error("status word without tlast");

    // A payload word that is not last is followed straight by its status word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tready && m_axis_tuser == cse_pkg::KIND_PAYLOAD
         && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tuser == cse_pkg::KIND_STATUS))
        else $error("payload word not followed by its status word");

    // A payload word carries no status and no total.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == cse_pkg::KIND_PAYLOAD)
        |-> (m_axis_tdata[cse_pkg::OUT_TDATA_W-1:8] == '0))
        else $error("payload word with status fields set");

    // A failing status reports a total of zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser == cse_pkg::KIND_STATUS
         && m_axis_tdata[10:8] != 3'(cse_pkg::ST_OK)) |-> (m_axis_tdata[42:11] == 32'd0))
        else $error("error status with a nonzero total");

endmodule

// ===== hdl/chunked_stream_substream_extractor_top.sv =====
// Path: a result word reaches the m_axis side from its accepted input word through the result
// queue and then the output register.
// Throughput: one input word per cycle while s_axis_tready is high; an input with a payload
// byte and status gives two output words, absorbed by a four-entry queue until tready drops.
// The front parser keeps all per-byte state in counters and shift registers, so nothing loops.
// Reset (aresetn low, synchronous) clears the parser, the queue and the output valid flag,
// and sets wanted_chunk_type to zero; the end of each file also returns the parser to reset.
module chunked_stream_substream_extractor_top #(
    parameter int FILE_HEADER_BYTES  = 244,
    parameter int CHUNK_HEADER_BYTES = 24
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration: wanted_chunk_type.
    input  logic                            cfg_we,
    input  logic [31:0]                     cfg_wdata,
    // Input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [7:0]                      s_axis_tdata,  // [7:0] file_byte
    input  logic                            s_axis_tlast,  // final_byte
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] payload_byte, [10:8] status_code, [42:11] total_bytes, [47:43] zero
    output logic [cse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tuser,  // result_kind
    output logic                            m_axis_tlast   // run_last
);

    logic                   in_accept;
    logic                   push;
    cse_pkg::result_entry_t push_entry;
    logic                   pop;
    logic                   head_valid;
    cse_pkg::result_entry_t head;
    logic                   full;

    assign s_axis_tready = !full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Front: header checks, chunk parsing and payload selection.
    cse_front #(
        .FILE_HEADER_BYTES  (FILE_HEADER_BYTES),
        .CHUNK_HEADER_BYTES (CHUNK_HEADER_BYTES)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_accept (in_accept),
        .in_byte   (s_axis_tdata),
        .in_final  (s_axis_tlast),
        .push      (push),
        .entry     (push_entry)
    );

    // Result queue.
    cse_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .full       (full)
    );

    // Back: serialises entries into output words.
    cse_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head_valid    (head_valid),
        .head          (head),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
